// ===== rtl/hte_pkg.sv =====
// Shared types, constants and constant tables of the harmonic tide evaluator.
package hte_pkg;

  localparam int ROM_LEN = 31;
  localparam int KW      = 5;
  localparam int Q_BITS  = 17;

  localparam logic [14:0] MEAN_RESET  = 15'd10813;
  localparam logic [33:0] EPOCH       = 34'd1546301340;
  localparam logic [63:0] DEG_RAD_Q32 = 64'd74961321;
  localparam logic [63:0] TURN_SCALED = 64'd12960000000000;

  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;

  localparam logic [10:0] DIV_D = 11'd625;

  // pass / destination codes
  localparam logic [1:0] DST_H = 2'd0;
  localparam logic [1:0] DST_S = 2'd1;
  localparam logic [1:0] DST_C = 2'd2;

  typedef logic [31:0] raw_tab_t  [ROM_LEN];
  typedef logic [55:0] rate_tab_t [ROM_LEN];
  typedef logic [23:0] ph_tab_t   [ROM_LEN];

  typedef struct packed {
    logic        v;
    logic        neg;
    logic [1:0]  dst;
    logic [31:0] coef;
    logic [30:0] z;
    logic [30:0] z2;
  } tok_t;

  localparam raw_tab_t AMP_RAW = '{
    32'd16236, 32'd4758, 32'd2846, 32'd1624, 32'd1031, 32'd1272, 32'd361, 32'd415,
    32'd913, 32'd824, 32'd306, 32'd1087, 32'd224, 32'd301, 32'd475, 32'd63,
    32'd49, 32'd65, 32'd83, 32'd525, 32'd225, 32'd184, 32'd63, 32'd9,
    32'd92, 32'd48, 32'd70, 32'd198, 32'd266, 32'd87, 32'd75};

  localparam raw_tab_t RATE_RAW = '{
    32'd289841042, 32'd300000000, 32'd284397295, 32'd300821373, 32'd150410686,
    32'd139430356, 32'd149589314, 32'd133986609, 32'd279682084, 32'd285125831,
    32'd278953548, 32'd295284789, 32'd299589333, 32'd310158958, 32'd294556253,
    32'd155854433, 32'd161391017, 32'd128542862, 32'd134715145, 32'd579682084,
    32'd589841042, 32'd574238337, 32'd590662415, 32'd600000000, 32'd869523127,
    32'd864079380, 32'd879682084, 32'd440251729, 32'd429271398, 32'd10980331,
    32'd5443747};

  localparam raw_tab_t PH_RAW = '{
    32'd209601, 32'd30617, 32'd263418, 32'd196250, 32'd357212, 32'd59267,
    32'd354719, 32'd79892, 32'd187004, 32'd330693, 32'd313497, 32'd324568,
    32'd15603, 32'd14171, 32'd245613, 32'd22363, 32'd77357, 32'd127521,
    32'd152544, 32'd38983, 32'd232210, 32'd87083, 32'd39766, 32'd20681,
    32'd346092, 32'd33689, 32'd165004, 32'd128877, 32'd201290, 32'd104409,
    32'd48050};

  function automatic logic [55:0] rate_q56(input logic [63:0] x);
    logic [63:0] q;
    logic [63:0] r;
    q = x / TURN_SCALED;
    r = x % TURN_SCALED;
    for (int i = 0; i < 57; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= TURN_SCALED) begin
        r = r - TURN_SCALED;
        q = q | 64'd1;
      end
    end
    return 56'((q + 64'd1) >> 1);
  endfunction

  function automatic logic [63:0] omega_q32(input logic [31:0] raw);
    return (64'(raw) * DEG_RAD_Q32 + 64'd5000000) / 64'd10000000;
  endfunction

  function automatic rate_tab_t mk_rate_tab();
    rate_tab_t tab;
    for (int k = 0; k < ROM_LEN; k++) tab[k] = rate_q56(64'(RATE_RAW[k]));
    return tab;
  endfunction

  function automatic ph_tab_t mk_ph_tab();
    ph_tab_t tab;
    for (int k = 0; k < ROM_LEN; k++) begin
      tab[k] = 24'((((64'(PH_RAW[k]) << 25) / 64'd360000) + 64'd1) >> 1);
    end
    return tab;
  endfunction

  function automatic raw_tab_t mk_aw_tab(input logic sq);
    raw_tab_t tab;
    logic [63:0] w;
    logic [63:0] aw;
    for (int k = 0; k < ROM_LEN; k++) begin
      w  = omega_q32(RATE_RAW[k]);
      aw = (64'(AMP_RAW[k]) * w) >> 16;
      tab[k] = sq ? 32'((aw * w) >> 32) : 32'(aw);
    end
    return tab;
  endfunction

  localparam rate_tab_t RATE_TAB = mk_rate_tab();
  localparam ph_tab_t   PH_TAB   = mk_ph_tab();
  localparam raw_tab_t  AW_TAB   = mk_aw_tab(1'b0);
  localparam raw_tab_t  AW2_TAB  = mk_aw_tab(1'b1);

endpackage

// ===== rtl/hte_ifs.sv =====
// Channel interfaces of the harmonic tide evaluator.
interface hte_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;
  modport source (output valid, unix_seconds, input ready);
  modport sink (input valid, unix_seconds, output ready);
endinterface

interface hte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] height;
  logic signed [15:0] slope;
  logic signed [15:0] curvature;
  modport source (output valid, height, slope, curvature, input ready);
  modport sink (input valid, height, slope, curvature, output ready);
endinterface

interface hte_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] mean_level;
  modport source (output valid, mean_level, input ready);
  modport sink (input valid, mean_level, output ready);
endinterface

// ===== rtl/hte_horner_cell.sv =====
// One Horner step of the quarter-wave sine polynomial: r = C - (r * z2) >> 30.
module hte_horner_cell #(
  parameter logic [30:0] C_K = 31'd0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hte_pkg::tok_t tok_i,
  input  logic [30:0]   r_i,
  output hte_pkg::tok_t tok_o,
  output logic [30:0]   r_o
);

  logic [61:0]   prod;
  logic [30:0]   r_nxt;
  hte_pkg::tok_t tok_nxt;
  hte_pkg::tok_t tok_r;
  logic [30:0]   r_r;

  assign prod  = 62'(r_i) * 62'(tok_i.z2);
  assign r_nxt = C_K - prod[60:30];

  always_comb begin
    tok_nxt   = tok_i;
    tok_nxt.v = tok_i.v && rst_n;
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    r_r   <= r_nxt;
  end

  assign tok_o = tok_r;
  assign r_o   = r_r;

endmodule

// ===== rtl/hte_rdiv.sv =====
// Round-to-nearest divide by 625 * 2^SHIFT through a reciprocal multiply, with saturation.
module hte_rdiv #(
  parameter int SHIFT = 22
) (
  input  logic               clk,
  input  logic               load,
  input  logic               step,
  input  logic signed [63:0] sum_i,
  input  logic signed [14:0] ofs_i,
  output logic signed [15:0] res_o
);

  localparam logic [63:0] HALF  = 64'(hte_pkg::DIV_D) << (SHIFT - 1);
  // ceil(2^37 / 625); exact for every 27-bit dividend
  localparam logic [27:0] RECIP = 28'd219902326;
  localparam int          R_SH  = 37;

  logic        neg_r, ovf_r;
  logic [26:0] mq_r;
  logic [16:0] q_r;

  logic [63:0] mag, m, mq;
  logic        ovf;
  logic [54:0] qprod;
  logic signed [17:0] sq;
  logic signed [18:0] v;

  assign mag   = sum_i[63] ? (64'd0 - 64'(sum_i)) : 64'(sum_i);
  assign m     = mag + HALF;
  assign mq    = m >> SHIFT;
  assign ovf   = (m >> (SHIFT + hte_pkg::Q_BITS)) >= 64'(hte_pkg::DIV_D);
  assign qprod = 55'(mq_r) * 55'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= sum_i[63];
      ovf_r <= ovf;
      mq_r  <= mq[26:0];
    end
    if (step) begin
      q_r <= qprod[R_SH+16:R_SH];
    end
  end

  assign sq = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign v  = 19'(sq) + 19'(ofs_i);

  always_comb begin
    if (ovf_r) begin
      res_o = neg_r ? -16'sd32768 : 16'sd32767;
    end else if (v > 19'sd32767) begin
      res_o = 16'sd32767;
    end else if (v < -19'sd32768) begin
      res_o = -16'sd32768;
    end else begin
      res_o = v[15:0];
    end
  end

endmodule

// ===== rtl/harmonic_tide_evaluator.sv =====
// One item at a time: the next input is taken in the cycle the result is first offered.
// The phase comes from the shared phase multiplier, three partial products per term, which
// feeds one pass per cycle down the Horner cell row; each sum is then divided through a
// reciprocal multiply. Synchronous active-low reset; mean_level resets to 10813.
module harmonic_tide_evaluator #(
  parameter int NUM_TERMS     = 31,
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  hte_in_if.sink     in_if,
  hte_out_if.source  out_if,
  hte_cfg_if.sink    cfg_if
);

  localparam int NT   = (NUM_TERMS < hte_pkg::ROM_LEN) ? NUM_TERMS : hte_pkg::ROM_LEN;
  localparam int SH_H = 34 - OUT_FRAC_BITS;
  localparam int SH_S = 50 - OUT_FRAC_BITS;
  localparam logic [hte_pkg::KW-1:0] K_END = hte_pkg::KW'(NT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [1:0] PART_LO = 2'd0;
  localparam logic [1:0] PART_X1 = 2'd1;
  localparam logic [1:0] PART_X2 = 2'd2;

  localparam logic [30:0] HCOEF [4] = '{hte_pkg::C7, hte_pkg::C5, hte_pkg::C3, hte_pkg::C1};

  logic [1:0]  state_r;
  logic signed [14:0] mean_r;

  // time and phase multiplier
  logic [hte_pkg::KW-1:0] k_r;
  logic [1:0]  p_r;
  logic [31:0] tl_r;
  logic [23:0] th_r;
  logic [33:0] t34;
  logic [55:0] rate_k;
  logic [31:0] opa, opb;
  logic        issue;

  logic        mv_r;
  logic [1:0]  msel_r;
  logic [hte_pkg::KW-1:0] mk_r;
  logic [23:0] mph_r;
  logic [63:0] mp_r;

  logic [23:0] acc_r;
  logic [hte_pkg::KW-1:0] kacc_r;
  logic        accf_r;

  logic [23:0] a_r;
  logic [hte_pkg::KW-1:0] ka_r;
  logic        av_r;
  logic [1:0]  q_r;

  // pass issue
  logic [1:0]  quad;
  logic [21:0] f;
  logic [22:0] fc, z23;
  logic        neg_pass;
  logic [31:0] coef_pass;
  hte_pkg::tok_t tokz_r, tokq_r;
  hte_pkg::tok_t tokq_nxt;
  logic [61:0] zz;

  hte_pkg::tok_t tok_w [5];
  logic [30:0]   r_w [5];

  hte_pkg::tok_t ytok_r;
  hte_pkg::tok_t ytok_nxt;
  logic [31:0] y_r;
  logic [61:0] yprod;

  logic        pv_r;
  logic [1:0]  pdst_r;
  logic signed [63:0] pterm_r;
  logic [63:0] pm;

  logic signed [63:0] hsum_r, ssum_r, csum_r;

  logic        pipe_busy, run_done, lane_load, lane_step;
  logic signed [15:0] res_h, res_s, res_c;

  logic        out_v_r;
  logic signed [15:0] oh_r, os_r, oc_r;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign t34    = {2'b00, in_if.unix_seconds} - hte_pkg::EPOCH;
  assign rate_k = hte_pkg::RATE_TAB[k_r];
  assign issue  = (state_r == S_RUN) && (k_r < K_END);

  always_comb begin
    case (p_r)
      PART_LO: begin
        opa = rate_k[31:0];
        opb = tl_r;
      end
      PART_X1: begin
        opa = {8'b0, rate_k[23:0]};
        opb = {8'b0, th_r};
      end
      default: begin
        opa = {8'b0, rate_k[55:32]};
        opb = {8'b0, tl_r[23:0]};
      end
    endcase
  end

  // pass operands: q 0 height (cos), 1 slope (sin), 2 curvature (cos)
  assign quad = a_r[23:22];
  assign f    = a_r[21:0];
  assign fc   = 23'h400000 - {1'b0, f};

  always_comb begin
    if (q_r == hte_pkg::DST_S) begin
      z23      = quad[0] ? fc : {1'b0, f};
      neg_pass = ~quad[1];
    end else begin
      z23      = quad[0] ? {1'b0, f} : fc;
      neg_pass = quad[0] ^ quad[1] ^ (q_r == hte_pkg::DST_C);
    end
    case (q_r)
      hte_pkg::DST_H: coef_pass = hte_pkg::AMP_RAW[ka_r];
      hte_pkg::DST_S: coef_pass = hte_pkg::AW_TAB[ka_r];
      default:        coef_pass = hte_pkg::AW2_TAB[ka_r];
    endcase
  end

  assign zz    = 62'(tokz_r.z) * 62'(tokz_r.z);
  assign yprod = 62'(r_w[4]) * 62'(tok_w[4].z);
  assign pm    = 64'(ytok_r.coef) * 64'(y_r);

  always_comb begin
    tokq_nxt    = tokz_r;
    tokq_nxt.z2 = zz[60:30];
    tokq_nxt.v  = tokz_r.v && rst_n;
    ytok_nxt    = tok_w[4];
    ytok_nxt.v  = tok_w[4].v && rst_n;
  end

  assign tok_w[0] = tokq_r;
  assign r_w[0]   = hte_pkg::C9;

  genvar gi;
  generate
    for (gi = 0; gi < 4; gi++) begin : g_cell
      hte_horner_cell #(.C_K(HCOEF[gi])) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .tok_i (tok_w[gi]),
        .r_i   (r_w[gi]),
        .tok_o (tok_w[gi+1]),
        .r_o   (r_w[gi+1])
      );
    end
  endgenerate

  assign pipe_busy = mv_r | accf_r | av_r | tokz_r.v | tokq_r.v | tok_w[1].v | tok_w[2].v
                   | tok_w[3].v | tok_w[4].v | ytok_r.v | pv_r;
  assign run_done  = (state_r == S_RUN) && (k_r == K_END) && !pipe_busy;
  assign lane_load = run_done;
  assign lane_step = (state_r == S_DIV);

  hte_rdiv #(.SHIFT(SH_H)) u_div_h (
    .clk(clk), .load(lane_load), .step(lane_step), .sum_i(hsum_r), .ofs_i(mean_r),
    .res_o(res_h)
  );
  hte_rdiv #(.SHIFT(SH_S)) u_div_s (
    .clk(clk), .load(lane_load), .step(lane_step), .sum_i(ssum_r), .ofs_i(15'sd0),
    .res_o(res_s)
  );
  hte_rdiv #(.SHIFT(SH_S)) u_div_c (
    .clk(clk), .load(lane_load), .step(lane_step), .sum_i(csum_r), .ofs_i(15'sd0),
    .res_o(res_c)
  );

  // sequencer and phase unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mean_r  <= hte_pkg::MEAN_RESET;
      k_r     <= '0;
      p_r     <= PART_LO;
      mv_r    <= 1'b0;
      accf_r  <= 1'b0;
      av_r    <= 1'b0;
      q_r     <= hte_pkg::DST_H;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        mean_r <= cfg_if.mean_level;
      end

      mv_r   <= issue;
      accf_r <= mv_r && (msel_r == PART_X2);
      if (issue) begin
        if (p_r == PART_X2) begin
          p_r <= PART_LO;
          k_r <= k_r + 1'b1;
        end else begin
          p_r <= p_r + 1'b1;
        end
      end

      if (accf_r) begin
        av_r <= 1'b1;
        q_r  <= hte_pkg::DST_H;
      end else if (av_r) begin
        if (q_r == hte_pkg::DST_C) begin
          av_r <= 1'b0;
        end else begin
          q_r <= q_r + 1'b1;
        end
      end

      if ((state_r == S_FIN) && (!out_v_r || out_if.ready)) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            state_r <= S_RUN;
            k_r     <= '0;
            p_r     <= PART_LO;
          end
        end
        S_RUN: begin
          if (run_done) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_v_r || out_if.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      tl_r <= t34[31:0];
      th_r <= {{22{t34[33]}}, t34[33:32]};
    end

    msel_r <= p_r;
    mk_r   <= k_r;
    mph_r  <= hte_pkg::PH_TAB[k_r];
    mp_r   <= 64'(opa) * 64'(opb);

    if (mv_r) begin
      if (msel_r == PART_LO) begin
        acc_r  <= mp_r[55:32] - mph_r;
        kacc_r <= mk_r;
      end else begin
        acc_r <= acc_r + mp_r[23:0];
      end
    end

    if (accf_r) begin
      a_r  <= acc_r;
      ka_r <= kacc_r;
    end

    tokz_r.v    <= av_r && rst_n;
    tokz_r.neg  <= neg_pass;
    tokz_r.dst  <= q_r;
    tokz_r.coef <= coef_pass;
    tokz_r.z    <= {z23, 8'b0};
    tokz_r.z2   <= '0;

    tokq_r <= tokq_nxt;

    ytok_r <= ytok_nxt;
    y_r    <= yprod[61:30];

    pdst_r  <= ytok_r.dst;
    pterm_r <= ytok_r.neg ? -$signed(pm) : $signed(pm);

    if (in_if.valid && in_if.ready) begin
      hsum_r <= '0;
      ssum_r <= '0;
      csum_r <= '0;
    end else if (pv_r) begin
      case (pdst_r)
        hte_pkg::DST_H: hsum_r <= hsum_r + pterm_r;
        hte_pkg::DST_S: ssum_r <= ssum_r + pterm_r;
        default:        csum_r <= csum_r + pterm_r;
      endcase
    end

    if ((state_r == S_FIN) && (!out_v_r || out_if.ready)) begin
      oh_r <= res_h;
      os_r <= res_s;
      oc_r <= res_c;
    end

    pv_r <= ytok_r.v && rst_n;
  end

  assign out_if.valid     = out_v_r;
  assign out_if.height    = oh_r;
  assign out_if.slope     = os_r;
  assign out_if.curvature = oc_r;

endmodule
